@@ rtl/ifmt_pkg.sv @@
// ifmt_pkg: shared types and constants for the integer to ASCII formatter.
// Used by integer_to_ascii_formatter and tb_top; depends on nothing.
package ifmt_pkg;

    localparam int FIELD_BITS = 32;      // width of the value field on the port

    typedef struct packed {
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] value;
        logic [4:0]            pad_width;
        logic [1:0]            hex_size;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIZE,
        S_EMIT
    } t_state;

    // mode codes; the unused code falls back to unsigned decimal
    localparam logic [1:0] MODE_UDEC = 2'd0;
    localparam logic [1:0] MODE_SDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    // hex digit count codes
    localparam logic [1:0] HSZ_ONE   = 2'd0;
    localparam logic [1:0] HSZ_TWO   = 2'd1;
    localparam logic [1:0] HSZ_FOUR  = 2'd2;
    localparam logic [1:0] HSZ_EIGHT = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_MINUS = 7'h2D;

endpackage

@@ rtl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter. Takes one request (mode, value, pad width, hex size) and
// sends its characters one per output request, the final one flagged with last. A hex
// request goes straight to emitting one character per digit (1, 2, 4 or 8). A decimal
// request goes through the shift-and-add-3 converter, one value bit per cycle; then a
// sizing state sets the field width, and the characters are sent one per cycle while
// the output does not stall (the larger of the digit count plus sign and the pad
// width). The input stays stalled until the last character has been sent, so a new
// request is not accepted before then; output stalls stretch the character phase.
// The last character may still sit in the output register when the next is accepted.
// Depends on ifmt_pkg and ifmt_bcd.
module integer_to_ascii_formatter #(
    parameter int MAX_PAD    = 20,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ifmt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ifmt_pkg::t_out_item o_out_data
);

    localparam int FB        = ifmt_pkg::FIELD_BITS;
    // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
    localparam int DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CHARS     = (MAX_PAD > DIGITS + 1) ? MAX_PAD : DIGITS + 1;
    localparam int REM_W     = $clog2(CHARS + 1);
    localparam int DIG_IDX_W = $clog2(DIGITS);

    ifmt_pkg::t_state r_state, n_state;

    logic [REM_W-1:0]      r_rem;
    logic [REM_W-1:0]      r_pad;
    logic                  r_neg;
    logic                  r_hex_mode;
    logic [FB-1:0]         r_hex;
    logic                  r_out_valid;
    ifmt_pkg::t_out_item   r_out;

    logic [VALUE_BITS-1:0] w_v;
    logic [FB-1:0]         w_hexv;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_accept;
    logic                  w_start;
    logic                  w_fire;
    logic                  w_busy;
    logic [DIGITS*4-1:0]   w_bcd;
    logic [REM_W-1:0]      w_nd;
    logic [REM_W-1:0]      w_width;
    logic [REM_W-1:0]      w_hex_cnt;
    logic [REM_W-1:0]      w_k;
    logic [3:0]            w_digit;
    logic [3:0]            w_nib;
    logic [6:0]            w_char;

    // value as seen at VALUE_BITS, and the same masked value for hex output
    generate
        if (VALUE_BITS <= FB) begin : g_narrow
            assign w_v    = i_in_data.value[VALUE_BITS-1:0];
            if (VALUE_BITS < FB) begin : g_mask
                assign w_hexv = {{(FB - VALUE_BITS){1'b0}}, i_in_data.value[VALUE_BITS-1:0]};
            end else begin : g_full
                assign w_hexv = i_in_data.value;
            end
        end else begin : g_wide
            assign w_v    = {{(VALUE_BITS - FB){1'b0}}, i_in_data.value};
            assign w_hexv = i_in_data.value;
        end
    endgenerate

    assign w_neg = (i_in_data.mode == ifmt_pkg::MODE_SDEC) && w_v[VALUE_BITS-1];
    assign w_mag = w_neg ? (~w_v + 1'b1) : w_v;

    always_comb begin
        case (i_in_data.hex_size)
            ifmt_pkg::HSZ_ONE:  w_hex_cnt = REM_W'(1);
            ifmt_pkg::HSZ_TWO:  w_hex_cnt = REM_W'(2);
            ifmt_pkg::HSZ_FOUR: w_hex_cnt = REM_W'(4);
            default:            w_hex_cnt = REM_W'(8);
        endcase
    end

    ifmt_bcd #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (w_mag),
        .o_busy  (w_busy),
        .o_bcd   (w_bcd)
    );

    // digit count: index of the highest nonzero digit plus one, at least one
    always_comb begin
        w_nd = REM_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            if (w_bcd[i*4 +: 4] != 4'd0) begin
                w_nd = REM_W'(i + 1);
            end
        end
        w_width = w_nd + REM_W'(r_neg);
    end

    // k counts characters left after this one; zero marks the last
    assign w_k     = r_rem - 1'b1;
    assign w_digit = w_bcd[w_k[DIG_IDX_W-1:0]*4 +: 4];
    assign w_nib   = r_hex[w_k[2:0]*4 +: 4];

    always_comb begin
        if (r_hex_mode) begin
            if (w_nib <= 4'd9) begin
                w_char = ifmt_pkg::CH_ZERO + {3'b000, w_nib};
            end else begin
                w_char = ifmt_pkg::CH_A + {3'b000, w_nib} - 7'd10;
            end
        end else if (w_k < w_nd) begin
            w_char = ifmt_pkg::CH_ZERO + {3'b000, w_digit};
        end else if (r_neg && (w_k == w_nd)) begin
            w_char = ifmt_pkg::CH_MINUS;
        end else begin
            w_char = ifmt_pkg::CH_SPACE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifmt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.mode == ifmt_pkg::MODE_HEX) ?
                              ifmt_pkg::S_EMIT : ifmt_pkg::S_CONV;
                end
            end
            ifmt_pkg::S_CONV: begin
                if (!w_busy) begin
                    n_state = ifmt_pkg::S_SIZE;
                end
            end
            ifmt_pkg::S_SIZE: n_state = ifmt_pkg::S_EMIT;
            ifmt_pkg::S_EMIT: begin
                if (w_fire && (r_rem == REM_W'(1))) begin
                    n_state = ifmt_pkg::S_IDLE;
                end
            end
            default: n_state = ifmt_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != ifmt_pkg::S_IDLE);
        w_accept   = i_in_valid && (r_state == ifmt_pkg::S_IDLE);
        w_start    = w_accept && (i_in_data.mode != ifmt_pkg::MODE_HEX);
        w_fire     = (r_state == ifmt_pkg::S_EMIT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifmt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_rem <= w_hex_cnt;
            end else if (r_state == ifmt_pkg::S_SIZE) begin
                r_rem <= (w_width > r_pad) ? w_width : r_pad;
            end else if (w_fire) begin
                r_rem <= w_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hex_mode <= (i_in_data.mode == ifmt_pkg::MODE_HEX);
            r_neg      <= w_neg;
            r_hex      <= w_hexv;
            if (int'(i_in_data.pad_width) > MAX_PAD) begin
                r_pad <= REM_W'(MAX_PAD);
            end else begin
                r_pad <= REM_W'(i_in_data.pad_width);
            end
        end
        if (w_fire) begin
            r_out.char_code <= w_char;
            r_out.last      <= (r_rem == REM_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/ifmt_bcd.sv @@
// ifmt_bcd: iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Stand-alone; no package dependencies.
module ifmt_bcd #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_BITS-1:0]   i_mag,
    output logic                    o_busy,
    output logic [DIGITS*4-1:0]     o_bcd
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin;
    logic [DIGITS*4-1:0]   r_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic [DIGITS*4-1:0]   w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {w_adj[DIGITS*4-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for integer_to_ascii_formatter.
// Predicts every character of each accepted request and compares it in order with the output.
// Depends on ifmt_pkg and the formatter RTL.
module tb_top;

    localparam int MAX_PAD      = 20;
    localparam int VALUE_BITS   = 32;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, handled as unsigned

    logic                i_clk;
    logic                i_rst_n;
    logic                req_valid;
    logic                req_stall;
    ifmt_pkg::t_in_item  req_data;
    logic                chr_valid;
    logic                chr_stall;
    ifmt_pkg::t_out_item chr_data;

    ifmt_pkg::t_out_item expected_chars [$];
    ifmt_pkg::t_out_item head_char;
    int                  mismatches;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_cycles;

    integer_to_ascii_formatter #(
        .MAX_PAD    (MAX_PAD),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (chr_valid),
        .i_out_stall (chr_stall),
        .o_out_data  (chr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Characters a request should produce, appended to expected_chars.
    function automatic void format_value(input ifmt_pkg::t_in_item req);
        logic [6:0]            chars [$];
        logic [6:0]            digits [$];
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            nib;
        int                    cnt;
        int                    width;
        int                    pad;
        bit                    neg;
        ifmt_pkg::t_out_item   item;
        if (req.mode == ifmt_pkg::MODE_HEX) begin
            case (req.hex_size)
                ifmt_pkg::HSZ_ONE:  cnt = 1;
                ifmt_pkg::HSZ_TWO:  cnt = 2;
                ifmt_pkg::HSZ_FOUR: cnt = 4;
                default:            cnt = 8;
            endcase
            for (int i = cnt - 1; i >= 0; i--) begin
                nib = req.value[i*4 +: 4];
                chars.push_back(nib <= 4'd9 ? ifmt_pkg::CH_ZERO + 7'(nib)
                                            : ifmt_pkg::CH_A + 7'(nib) - 7'd10);
            end
        end else begin
            neg = (req.mode == ifmt_pkg::MODE_SDEC) && req.value[VALUE_BITS-1];
            mag = neg ? ~req.value + 1'b1 : req.value;
            do begin
                digits.push_front(ifmt_pkg::CH_ZERO + 7'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            width = digits.size() + (neg ? 1 : 0);
            pad   = (req.pad_width > MAX_PAD) ? MAX_PAD : int'(req.pad_width);
            while (width < pad) begin
                chars.push_back(ifmt_pkg::CH_SPACE);
                width++;
            end
            if (neg)
                chars.push_back(ifmt_pkg::CH_MINUS);
            foreach (digits[i])
                chars.push_back(digits[i]);
        end
        foreach (chars[i]) begin
            item.char_code = chars[i];
            item.last      = (i == chars.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    function automatic ifmt_pkg::t_in_item make_request(logic [1:0] mode, logic [31:0] value,
                                                        logic [4:0] pad, logic [1:0] hsz);
        ifmt_pkg::t_in_item req;
        req.mode      = mode;
        req.value     = value;
        req.pad_width = pad;
        req.hex_size  = hsz;
        return req;
    endfunction

    // Entered and left at a falling edge; valid stays high after acceptance so
    // back-to-back requests are driven without dropping valid.
    task automatic send_request(input ifmt_pkg::t_in_item req);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        do @(posedge i_clk); while (req_stall);
        format_value(req);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input ifmt_pkg::t_out_item want,
                                 input ifmt_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected char %h last %b, got char %h last %b",
                     $realtime, what, want.char_code, want.last, got.char_code, got.last);
    endtask

    // receiver: random stall, or a forced hold-off while hold_cycles runs down
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            chr_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            chr_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && chr_valid && !chr_stall) begin
            if (expected_chars.size() == 0) begin
                head_char = '0;
                note_mismatch("unexpected character", head_char, chr_data);
            end else begin
                head_char = expected_chars.pop_front();
                if (chr_data.char_code !== head_char.char_code || chr_data.last !== head_char.last)
                    note_mismatch("character mismatch", head_char, chr_data);
            end
        end
    end

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = $urandom_range(0, 99999);
            3: v = -$urandom_range(1, 99999);
            4: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic test_hex_sizes();
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'hFEDC_BA98, 5'd31, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'hFEDC_BA98, 5'd0, ifmt_pkg::HSZ_TWO));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'hFEDC_BA98, 5'd20, ifmt_pkg::HSZ_FOUR));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'hFEDC_BA98, 5'd5, ifmt_pkg::HSZ_EIGHT));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'h0123_4567, 5'd0, ifmt_pkg::HSZ_EIGHT));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'h0000_0000, 5'd0, ifmt_pkg::HSZ_EIGHT));
        send_request(make_request(ifmt_pkg::MODE_HEX, 32'hFFFF_FFFF, 5'd0, ifmt_pkg::HSZ_EIGHT));
    endtask

    task automatic test_unsigned_decimal();
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'd0, 5'd0, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd0, ifmt_pkg::HSZ_EIGHT));
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd20, ifmt_pkg::HSZ_ONE));
        // pad saturates
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'd7, 5'd31, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'd42, 5'd1, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'd12345, 5'd10, ifmt_pkg::HSZ_ONE));
        // wider than pad
        send_request(make_request(ifmt_pkg::MODE_UDEC, 32'd123456, 5'd3, ifmt_pkg::HSZ_ONE));
        send_request(make_request(MODE_SPARE, 32'hFFFF_FFFF, 5'd12, ifmt_pkg::HSZ_TWO));
        send_request(make_request(MODE_SPARE, 32'd0, 5'd21, ifmt_pkg::HSZ_FOUR));
    endtask

    task automatic test_signed_decimal();
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'hFFFF_FFFF, 5'd0, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'h8000_0000, 5'd0, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'h8000_0000, 5'd20, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'h8000_0000, 5'd11, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'h7FFF_FFFF, 5'd12, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, -32'sd5, 5'd3, ifmt_pkg::HSZ_ONE));
        // '-' fills the width
        send_request(make_request(ifmt_pkg::MODE_SDEC, -32'sd5, 5'd2, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'd0, 5'd31, ifmt_pkg::HSZ_ONE));
        send_request(make_request(ifmt_pkg::MODE_SDEC, 32'd99, 5'd1, ifmt_pkg::HSZ_ONE));
    endtask

    task automatic test_random_requests(input int count, input int send_pct, input int recv_pct);
        ifmt_pkg::t_in_item req;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            req = make_request(2'($urandom_range(3)), random_value(),
                               5'($urandom_range(31)), 2'($urandom_range(3)));
            send_request(req);
        end
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        repeat (8)
            send_request(make_request(2'($urandom_range(3)), random_value(),
                                      5'($urandom_range(31)), 2'($urandom_range(3))));
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        chr_stall     = 1'b0;
        mismatches    = 0;
        hold_cycles   = 0;
        send_idle_pct = 21;
        recv_idle_pct = 69;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_hex_sizes();
        test_unsigned_decimal();
        test_signed_decimal();
        wait_drained();
        test_output_backpressure();
        test_random_requests(48, 21, 69);
        test_random_requests(48, 69, 21);
        test_random_requests(40, 0, 0);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
